### src/u8u16_pkg.sv
// Package for the UTF-8 to UTF-16 transcoder.
// Holds the decoder state and result types and the status and register codes.
// No dependencies.
`timescale 1ns / 1ps

package u8u16_pkg;

   // Status codes carried on every result
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_INVALID  = 2'd1;
   localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

   // Configuration register indexes
   localparam logic CSR_BIG_ENDIAN = 1'b0;
   localparam logic CSR_CAPACITY   = 1'b1;

   // Capacity register value after reset
   localparam logic [16:0] CAPACITY_RESET = 17'h10000;

   // Decoder state carried from one byte to the next
   typedef struct packed {
      logic [1:0]  pending;
      logic [1:0]  seq_len;
      logic [20:0] partial;
      logic [16:0] word_count;
      logic        discarding;
   } dec_state_type;

   // One result item
   typedef struct packed {
      logic [15:0] utf16_word;
      logic        last;
      logic [1:0]  status;
      logic [17:0] byte_total;
   } result_type;

endpackage

### src/u8u16_decode.sv
// Per-byte UTF-8 decode step: next decoder state and up to two results.
// Depends on u8u16_pkg.
`timescale 1ns / 1ps

module u8u16_decode (
   input  u8u16_pkg::dec_state_type cur_state,
   input  logic [7:0]               data_byte,
   input  logic                     big_endian,
   input  logic [16:0]              capacity,
   output u8u16_pkg::dec_state_type nxt_state,
   output logic [1:0]               num_results,
   output u8u16_pkg::result_type    result0,
   output u8u16_pkg::result_type    result1
);
   import u8u16_pkg::*;

   logic [20:0] cont_cp;
   logic [20:0] pair_v;
   logic [15:0] lead_word;
   logic [15:0] trail_word;
   logic [15:0] single_word;

   // Code point after appending the six payload bits of a continuation byte
   assign cont_cp = {cur_state.partial[14:0], data_byte[5:0]};

   // Swap the two bytes of a word when big-endian output is selected
   function automatic logic [15:0] order_word(input logic [15:0] w, input logic swap);
      return swap ? {w[7:0], w[15:8]} : w;
   endfunction

   always_comb begin
      logic        do_emit;
      logic        do_fail;
      logic [1:0]  fail_status;
      logic [20:0] emit_cp;
      logic        two_words;
      logic [17:0] wc_sum;

      nxt_state   = cur_state;
      num_results = 2'd0;
      result0     = '0;
      result1     = '0;
      do_emit     = 1'b0;
      do_fail     = 1'b0;
      fail_status = STATUS_OK;
      emit_cp     = '0;
      pair_v      = '0;
      lead_word   = '0;
      trail_word  = '0;
      single_word = '0;

      // Classify the byte against the current decoder state
      priority if (cur_state.discarding) begin
         if (data_byte == 8'h00) begin
            nxt_state.discarding = 1'b0;
         end
      end else if (cur_state.pending != 2'd0) begin
         if (data_byte[7:6] != 2'b10) begin
            do_fail     = 1'b1;
            fail_status = STATUS_INVALID;
         end else begin
            nxt_state.partial = cont_cp;
            nxt_state.pending = cur_state.pending - 2'd1;
            if (cur_state.pending == 2'd1) begin
               nxt_state.pending = 2'd0;
               nxt_state.seq_len = 2'd0;
               nxt_state.partial = '0;
               if (cur_state.seq_len == 2'd1 && cont_cp <= 21'd127) begin
                  // Overlong two-byte form
                  do_fail     = 1'b1;
                  fail_status = STATUS_INVALID;
               end else begin
                  do_emit = 1'b1;
                  emit_cp = cont_cp;
               end
            end
         end
      end else if (data_byte == 8'h00) begin
         // Terminator: zero word with the UTF-16 byte count of the string, terminator included
         result0.last       = 1'b1;
         result0.status     = STATUS_OK;
         result0.byte_total = {cur_state.word_count + 17'd1, 1'b0};
         num_results        = 2'd1;
         nxt_state.word_count = '0;
      end else if (data_byte < 8'h80) begin
         do_emit = 1'b1;
         emit_cp = {13'd0, data_byte};
      end else if (data_byte < 8'hC0) begin
         // Continuation byte outside a sequence
         do_fail     = 1'b1;
         fail_status = STATUS_INVALID;
      end else if (data_byte < 8'hE0) begin
         nxt_state.pending = 2'd1;
         nxt_state.seq_len = 2'd1;
         nxt_state.partial = {16'd0, data_byte[4:0]};
      end else if (data_byte < 8'hF0) begin
         nxt_state.pending = 2'd2;
         nxt_state.seq_len = 2'd2;
         nxt_state.partial = {17'd0, data_byte[3:0]};
      end else begin
         nxt_state.pending = 2'd3;
         nxt_state.seq_len = 2'd3;
         nxt_state.partial = {18'd0, data_byte[2:0]};
      end

      // Emit a finished code point, one word or a surrogate pair
      two_words = (emit_cp > 21'h00FFFF);
      wc_sum    = {1'b0, cur_state.word_count} + (two_words ? 18'd2 : 18'd1);
      if (do_emit) begin
         if (wc_sum >= {1'b0, capacity}) begin
            do_fail     = 1'b1;
            fail_status = STATUS_OVERFLOW;
         end else begin
            nxt_state.word_count = wc_sum[16:0];
            pair_v      = emit_cp - 21'h010000;
            lead_word   = 16'hD800 + {5'd0, pair_v[20:10]};
            trail_word  = 16'hDC00 + {6'd0, pair_v[9:0]};
            single_word = emit_cp[15:0];
            if (two_words) begin
               result0.utf16_word = order_word(lead_word, big_endian);
               result1.utf16_word = order_word(trail_word, big_endian);
               num_results        = 2'd2;
            end else begin
               result0.utf16_word = order_word(single_word, big_endian);
               num_results        = 2'd1;
            end
         end
      end

      // An error ends the string and starts discarding up to the next zero
      if (do_fail) begin
         nxt_state.pending    = 2'd0;
         nxt_state.seq_len    = 2'd0;
         nxt_state.partial    = '0;
         nxt_state.word_count = '0;
         nxt_state.discarding = (data_byte != 8'h00);
         result0              = '0;
         result0.last         = 1'b1;
         result0.status       = fail_status;
         result1              = '0;
         num_results          = 2'd1;
      end
   end

endmodule

### src/utf8_to_utf16_transcoder.sv
// Top level of the UTF-8 to UTF-16 transcoder: input register, decode, result queue.
// Depends on u8u16_pkg and u8u16_decode.
//
//   Channel  Ports                                         Direction
//   req      req_valid/req_ready, req_data_byte            in
//   rsp      rsp_valid/rsp_ready, rsp_utf16_word, rsp_last,
//            rsp_status, rsp_byte_total                    out
//   csr      csr_valid/csr_ready, csr_index, csr_wdata     in
//
// One byte is accepted per cycle while req_ready is high; a byte waits in the input
// register until the queue has room. A surrogate pair puts two words in the four-entry
// result queue and takes two output transfers; a byte is decoded only when the queue
// has two free entries, and its results then go from the decoder into the result queue.
// Reset clears the decoder state, the queue and the configuration registers to their defaults.
// A stalled result side fills the queue and then holds req_ready low.
`timescale 1ns / 1ps

module utf8_to_utf16_transcoder #(
   parameter int unsigned MAX_CAPACITY = 65536
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_utf16_word,
   output logic        rsp_last,
   output logic [1:0]  rsp_status,
   output logic [17:0] rsp_byte_total,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [16:0] csr_wdata
);
   import u8u16_pkg::*;

   // The capacity register cannot exceed 17 bits, so larger limits never bind
   localparam int unsigned CapLimitInt = (MAX_CAPACITY > 131071) ? 131071 : MAX_CAPACITY;
   localparam logic [16:0] CAP_LIMIT   = 17'(CapLimitInt);

   logic          big_endian_ff, big_endian_in;
   logic [16:0]   capacity_ff, capacity_in;
   logic          in_vld_ff, in_vld_in;
   logic [7:0]    in_byte_ff, in_byte_in;
   dec_state_type state_ff, state_in;
   result_type    slot_ff [4];
   result_type    slot_in [4];
   logic [1:0]    wr_ptr_ff, wr_ptr_in;
   logic [1:0]    rd_ptr_ff, rd_ptr_in;
   logic [2:0]    count_ff, count_in;

   logic          room;
   logic          fire;
   logic          pop;
   logic [16:0]   cap_eff;
   dec_state_type dec_next;
   logic [1:0]    dec_num;
   result_type    dec_res0;
   result_type    dec_res1;
   logic [2:0]    push_num;

   // Configuration registers; writes are always taken
   assign csr_ready = 1'b1;
   always_comb begin
      big_endian_in = big_endian_ff;
      capacity_in   = capacity_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_BIG_ENDIAN: big_endian_in = csr_wdata[0];
            CSR_CAPACITY:   capacity_in   = csr_wdata;
            default:        big_endian_in = big_endian_ff;
         endcase
      end
   end

   assign cap_eff = (capacity_ff > CAP_LIMIT) ? CAP_LIMIT : capacity_ff;

   // Input register: holds a byte until the queue can take its results
   assign room      = (count_ff <= 3'd2);
   assign fire      = in_vld_ff && room;
   assign req_ready = !in_vld_ff || room;
   assign in_vld_in = (req_valid && req_ready) ? 1'b1 : (fire ? 1'b0 : in_vld_ff);
   assign in_byte_in = (req_valid && req_ready) ? req_data_byte : in_byte_ff;

   u8u16_decode u_decode (
      .cur_state   (state_ff),
      .data_byte   (in_byte_ff),
      .big_endian  (big_endian_ff),
      .capacity    (cap_eff),
      .nxt_state   (dec_next),
      .num_results (dec_num),
      .result0     (dec_res0),
      .result1     (dec_res1)
   );

   assign state_in = fire ? dec_next : state_ff;

   // Result queue: up to two pushes per decode, one pop per output transfer
   assign pop      = rsp_valid && rsp_ready;
   assign push_num = fire ? {1'b0, dec_num} : 3'd0;
   always_comb begin
      slot_in = slot_ff;
      if (push_num != 3'd0) begin
         slot_in[wr_ptr_ff] = dec_res0;
      end
      if (push_num == 3'd2) begin
         slot_in[wr_ptr_ff + 2'd1] = dec_res1;
      end
      wr_ptr_in = wr_ptr_ff + push_num[1:0];
      rd_ptr_in = rd_ptr_ff + {1'b0, pop};
      count_in  = count_ff + push_num - {2'd0, pop};
   end

   assign rsp_valid      = (count_ff != 3'd0);
   assign rsp_utf16_word = slot_ff[rd_ptr_ff].utf16_word;
   assign rsp_last       = slot_ff[rd_ptr_ff].last;
   assign rsp_status     = slot_ff[rd_ptr_ff].status;
   assign rsp_byte_total = slot_ff[rd_ptr_ff].byte_total;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         big_endian_ff <= 1'b0;
         capacity_ff   <= CAPACITY_RESET;
         in_vld_ff     <= 1'b0;
         state_ff      <= '0;
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         count_ff      <= '0;
      end else begin
         big_endian_ff <= big_endian_in;
         capacity_ff   <= capacity_in;
         in_vld_ff     <= in_vld_in;
         state_ff      <= state_in;
         wr_ptr_ff     <= wr_ptr_in;
         rd_ptr_ff     <= rd_ptr_in;
         count_ff      <= count_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      slot_ff    <= slot_in;
   end

   // The queue never holds more than its four entries
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 3'd4)
      else $error("result queue count out of range");

   // Both words of a pair are ordinary, non-final results
   a_pair_ok: assert property (@(posedge clock) disable iff (reset)
      (fire && dec_num == 2'd2) |-> (dec_res0.status == STATUS_OK && !dec_res0.last
                                     && dec_res1.status == STATUS_OK && !dec_res1.last))
      else $error("surrogate pair marked as final or failed");

   // A final result always carries a zero word
   a_last_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |-> (rsp_utf16_word == 16'h0000))
      else $error("final result carries a nonzero word");

   // A held byte is kept until the queue has room for it
   a_hold_byte: assert property (@(posedge clock) disable iff (reset)
      (in_vld_ff && !room) |=> (in_vld_ff && $stable(in_byte_ff)))
      else $error("pending input byte lost");

   // Only errors set a non-ok status, and they are final
   a_status_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != STATUS_OK) |-> rsp_last)
      else $error("error result not marked final");

endmodule
